/* sv/pct_pkg.sv */
// Shared constants and types for the Park/Clarke transform pipeline.
`timescale 1ns / 1ps

package pct_pkg;

   // Number of register stages from the request port to the response register.
   localparam int N_STAGES = 13;

   // One advance-enable bit per pipeline stage.
   typedef logic [N_STAGES-1:0] stage_vec_type;

   // Unsigned Q16 position in a quarter wave, 0 to 65536 inclusive.
   localparam int X_W = 17;

   // Signed Q16 sine or cosine, -65536 to 65536 inclusive.
   localparam int SIN_W = 18;

   // Direction codes carried on the cmd field.
   localparam logic CMD_FORWARD = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

endpackage

/* sv/pct_sin_pipe.sv */
// Pipelined quarter-wave sine generator: Horner series over stages 1 to 7.
`timescale 1ns / 1ps

module pct_sin_pipe (
   input  logic                              clock,
   input  pct_pkg::stage_vec_type            adv,
   input  logic [pct_pkg::X_W-1:0]           x,
   input  logic                              neg,
   output logic signed [pct_pkg::SIN_W-1:0]  sin_val
);
   import pct_pkg::*;

   localparam int P_W = 26;
   localparam int R_W = 26;
   localparam int M_W = P_W + X_W;

   // Odd series of sin(pi/2 * x) in Q24, highest order first.
   localparam logic [P_W-1:0] C9 = P_W'(2692);
   localparam logic [P_W-1:0] C7 = P_W'(78547);
   localparam logic [P_W-1:0] C5 = P_W'(1337020);
   localparam logic [P_W-1:0] C3 = P_W'(10837479);
   localparam logic [P_W-1:0] C1 = P_W'(26353589);
   localparam logic [18:0]    CLAMP = 19'd65536;

   // One Horner step: c - floor(p * x2 / 2^16).
   function automatic logic [P_W-1:0] horner(input logic [P_W-1:0] c,
                                             input logic [P_W-1:0] p,
                                             input logic [X_W-1:0] x2);
      logic [M_W-1:0] prod;
      prod = {{X_W{1'b0}}, p} * {{P_W{1'b0}}, x2};
      return c - P_W'(prod >> 16);
   endfunction

   logic [X_W-1:0]          x_ff   [1:5];
   logic [X_W-1:0]          x2_ff  [1:4];
   logic                    neg_ff [1:6];
   logic [P_W-1:0]          p_ff   [2:5];
   logic [R_W-1:0]          r_ff;
   logic signed [SIN_W-1:0] sin_ff;

   logic [2*X_W-1:0]        sq_in;
   logic [M_W-1:0]          rprod_in;
   logic [18:0]             rnd_in;
   logic [X_W-1:0]          mag_in;
   logic signed [SIN_W-1:0] sin_in;

   // Square of the position, the final product and the rounded magnitude.
   always_comb begin
      sq_in    = {{X_W{1'b0}}, x} * {{X_W{1'b0}}, x};
      rprod_in = {{X_W{1'b0}}, p_ff[5]} * {{P_W{1'b0}}, x_ff[5]};
      rnd_in   = 19'((r_ff + R_W'(128)) >> 8);
      mag_in   = (rnd_in > CLAMP) ? X_W'(CLAMP) : X_W'(rnd_in);
      sin_in   = neg_ff[6] ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
   end

   // Stage registers; each stage moves when its advance bit is set.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         x_ff[1]   <= x;
         neg_ff[1] <= neg;
         x2_ff[1]  <= X_W'(sq_in >> 16);
      end
      if (adv[2]) begin
         x_ff[2]   <= x_ff[1];
         neg_ff[2] <= neg_ff[1];
         x2_ff[2]  <= x2_ff[1];
         p_ff[2]   <= horner(C7, C9, x2_ff[1]);
      end
      if (adv[3]) begin
         x_ff[3]   <= x_ff[2];
         neg_ff[3] <= neg_ff[2];
         x2_ff[3]  <= x2_ff[2];
         p_ff[3]   <= horner(C5, p_ff[2], x2_ff[2]);
      end
      if (adv[4]) begin
         x_ff[4]   <= x_ff[3];
         neg_ff[4] <= neg_ff[3];
         x2_ff[4]  <= x2_ff[3];
         p_ff[4]   <= horner(C3, p_ff[3], x2_ff[3]);
      end
      if (adv[5]) begin
         x_ff[5]   <= x_ff[4];
         neg_ff[5] <= neg_ff[4];
         p_ff[5]   <= horner(C1, p_ff[4], x2_ff[4]);
      end
      if (adv[6]) begin
         neg_ff[6] <= neg_ff[5];
         r_ff      <= R_W'(rprod_in >> 16);
      end
      if (adv[7]) begin
         sin_ff <= sin_in;
      end
   end

   assign sin_val = sin_ff;

endmodule

/* sv/park_clarke_transform_unit_core.sv */
// Three-phase Park/Clarke coordinate transform, forward and inverse, pipelined.
`timescale 1ns / 1ps

// The unit accepts one transaction per clock while the response side is not
// stalled. Thirteen register stages carry a valid bit each; a stage loads
// whenever it is empty or the stage after it moves, so a stalled response only
// holds back the stages that are full, and bubbles in the pipe are squeezed
// out. The sine and cosine generators (a seven-stage Horner series) set the
// depth; the Clarke scaling runs beside them and the Park rotation and phase
// recombination follow. The cmd bit selects forward (phases to d/q) or inverse
// (d/q to phases); the outputs of the unused direction read as zero. All
// results saturate.

module park_clarke_transform_unit_core #(
   parameter int VALUE_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [ANGLE_WIDTH-1:0]        req_angle,
   input  logic signed [VALUE_WIDTH-1:0] req_phase_a,
   input  logic signed [VALUE_WIDTH-1:0] req_phase_b,
   input  logic signed [VALUE_WIDTH-1:0] req_phase_c,
   input  logic signed [VALUE_WIDTH-1:0] req_axis_d,
   input  logic signed [VALUE_WIDTH-1:0] req_axis_q,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_res_d,
   output logic signed [VALUE_WIDTH-1:0] rsp_res_q,
   output logic signed [VALUE_WIDTH-1:0] rsp_res_a,
   output logic signed [VALUE_WIDTH-1:0] rsp_res_b,
   output logic signed [VALUE_WIDTH-1:0] rsp_res_c
);
   import pct_pkg::*;

   localparam int VW    = VALUE_WIDTH;
   localparam int POS_W = ANGLE_WIDTH - 2;
   localparam int UW    = VW + 2;
   localparam int BW    = VW + 1;
   localparam int PUW   = VW + 18;
   localparam int PVW   = VW + 17;
   localparam int OW    = VW + 3;
   localparam int MW    = OW + SIN_W;
   localparam int SW    = VW + 22;
   localparam int AL2W  = VW + 4;
   localparam int LAST  = N_STAGES - 1;

   // Q16 scale factors: one third, one over root three, root three over two.
   localparam logic signed [16:0] ONE_THIRD  = 17'sd21845;
   localparam logic signed [16:0] INV_SQRT3  = 17'sd37837;
   localparam logic signed [17:0] SQRT3_HALF = 18'sd56756;

   // Saturate a wide signed value to the output range.
   function automatic logic signed [VW-1:0] sat_val(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
      lo = ~hi;
      if (v > hi) return hi[VW-1:0];
      else if (v < lo) return lo[VW-1:0];
      else return v[VW-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Handshake: one valid bit per stage, a stage advances when it is empty
   // or its successor advances.
   // ---------------------------------------------------------------------
   stage_vec_type v_ff;
   stage_vec_type adv;

   always_comb begin
      adv[LAST] = !v_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < N_STAGES; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = v_ff[LAST];

   // ---------------------------------------------------------------------
   // Stage 0: angle to quarter-wave positions, Clarke sums.
   // ---------------------------------------------------------------------
   logic [1:0]       quad_sin;
   logic [1:0]       quad_cos;
   logic [POS_W-1:0] pos;
   logic [15:0]      frac_x;
   logic [X_W-1:0]   xs_in;
   logic [X_W-1:0]   xc_in;
   logic signed [UW-1:0] u_in;
   logic signed [BW-1:0] w_in;

   assign quad_sin = req_angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
   assign quad_cos = quad_sin + 2'd1;
   assign pos      = req_angle[POS_W-1:0];

   // Scale the position within the quadrant to Q16.
   if (ANGLE_WIDTH < 18) begin : g_frac_up
      assign frac_x = {pos, {(18-ANGLE_WIDTH){1'b0}}};
   end else if (ANGLE_WIDTH == 18) begin : g_frac_eq
      assign frac_x = pos;
   end else begin : g_frac_dn
      assign frac_x = pos[POS_W-1 -: 16];
   end

   // Odd quadrants run the quarter wave backwards.
   always_comb begin
      xs_in = quad_sin[0] ? (X_W'(65536) - {1'b0, frac_x}) : {1'b0, frac_x};
      xc_in = quad_cos[0] ? (X_W'(65536) - {1'b0, frac_x}) : {1'b0, frac_x};
      u_in  = (UW'(req_phase_a) <<< 1) - UW'(req_phase_b) - UW'(req_phase_c);
      w_in  = BW'(req_phase_b) - BW'(req_phase_c);
   end

   logic                 cmd_ff [0:LAST-1];
   logic [X_W-1:0]       xs_ff;
   logic [X_W-1:0]       xc_ff;
   logic                 ns_ff;
   logic                 nc_ff;
   logic signed [UW-1:0] u_ff;
   logic signed [BW-1:0] w_ff;
   logic signed [VW-1:0] d_ff [0:1];
   logic signed [VW-1:0] q_ff [0:1];

   // ---------------------------------------------------------------------
   // Stages 1 and 2: Clarke scaling products and rounding, operand select.
   // ---------------------------------------------------------------------
   logic signed [PUW-1:0] pu_in;
   logic signed [PVW-1:0] pv_in;
   logic signed [PUW-1:0] pu_ff;
   logic signed [PVW-1:0] pv_ff;
   logic signed [OW-1:0]  alpha_in;
   logic signed [OW-1:0]  beta_in;
   logic signed [OW-1:0]  op1_ff [2:7];
   logic signed [OW-1:0]  op2_ff [2:7];

   always_comb begin
      pu_in    = u_ff * ONE_THIRD;
      pv_in    = w_ff * INV_SQRT3;
      alpha_in = OW'((pu_ff + PUW'(1 <<< 13)) >>> 14);
      beta_in  = OW'((pv_ff + PVW'(1 <<< 13)) >>> 14);
   end

   // ---------------------------------------------------------------------
   // Stages 1 to 7: sine and cosine generators.
   // ---------------------------------------------------------------------
   logic signed [SIN_W-1:0] sin_val;
   logic signed [SIN_W-1:0] cos_val;

   pct_sin_pipe u_sin (
      .clock   (clock),
      .adv     (adv),
      .x       (xs_ff),
      .neg     (ns_ff),
      .sin_val (sin_val)
   );

   pct_sin_pipe u_cos (
      .clock   (clock),
      .adv     (adv),
      .x       (xc_ff),
      .neg     (nc_ff),
      .sin_val (cos_val)
   );

   // ---------------------------------------------------------------------
   // Stages 8 to 10: Park rotation products, sums, rounding.
   // ---------------------------------------------------------------------
   logic signed [MW-1:0]   m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [SW-1:0]   s1_in, s2_in;
   logic signed [SW-1:0]   s1_ff, s2_ff;
   logic signed [SW-1:0]   s1_r18, s2_r18, s1_r16;
   logic signed [VW-1:0]   r0_in;
   logic signed [VW-1:0]   r0_ff [10:11];
   logic signed [VW-1:0]   r1_ff [10:11];
   logic signed [AL2W-1:0] al2_in, be2_in;
   logic signed [AL2W-1:0] al2_ff, be2_ff;

   // Forward: d = a*cos + b*sin, q = b*cos - a*sin.
   // Inverse: al = d*cos - q*sin, be = d*sin + q*cos.
   always_comb begin
      if (cmd_ff[8] == CMD_INVERSE) begin
         s1_in = SW'(m1_ff) - SW'(m2_ff);
         s2_in = SW'(m3_ff) + SW'(m4_ff);
      end else begin
         s1_in = SW'(m1_ff) + SW'(m2_ff);
         s2_in = SW'(m4_ff) - SW'(m3_ff);
      end
      s1_r18 = (s1_ff + SW'(1 <<< 17)) >>> 18;
      s2_r18 = (s2_ff + SW'(1 <<< 17)) >>> 18;
      s1_r16 = (s1_ff + SW'(1 <<< 15)) >>> 16;
      r0_in  = (cmd_ff[9] == CMD_INVERSE) ? sat_val(s1_r16) : sat_val(s1_r18);
      al2_in = AL2W'((s1_ff + SW'(1 <<< 13)) >>> 14);
      be2_in = AL2W'((s2_ff + SW'(1 <<< 13)) >>> 14);
   end

   // ---------------------------------------------------------------------
   // Stages 11 and 12: phase b and c recombination, output register.
   // ---------------------------------------------------------------------
   logic signed [SW-1:0] pa_in, pb_in;
   logic signed [SW-1:0] pa_ff, pb_ff;
   logic signed [SW-1:0] tb, tc;
   logic signed [VW-1:0] res_b_in, res_c_in;
   logic signed [VW-1:0] res_d_ff, res_q_ff, res_a_ff, res_b_ff, res_c_ff;

   always_comb begin
      pa_in    = SW'(al2_ff) <<< 15;
      pb_in    = be2_ff * SQRT3_HALF;
      tb       = pb_ff - pa_ff;
      tc       = -pa_ff - pb_ff;
      res_b_in = sat_val((tb + SW'(1 <<< 17)) >>> 18);
      res_c_in = sat_val((tc + SW'(1 <<< 17)) >>> 18);
   end

   // Payload registers for every stage.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cmd_ff[0] <= req_cmd;
         xs_ff     <= xs_in;
         xc_ff     <= xc_in;
         ns_ff     <= quad_sin[1];
         nc_ff     <= quad_cos[1];
         u_ff      <= u_in;
         w_ff      <= w_in;
         d_ff[0]   <= req_axis_d;
         q_ff[0]   <= req_axis_q;
      end
      for (int k = 1; k < LAST; k++) begin
         if (adv[k]) cmd_ff[k] <= cmd_ff[k-1];
      end
      if (adv[1]) begin
         pu_ff   <= pu_in;
         pv_ff   <= pv_in;
         d_ff[1] <= d_ff[0];
         q_ff[1] <= q_ff[0];
      end
      if (adv[2]) begin
         if (cmd_ff[1] == CMD_INVERSE) begin
            op1_ff[2] <= OW'(d_ff[1]);
            op2_ff[2] <= OW'(q_ff[1]);
         end else begin
            op1_ff[2] <= alpha_in;
            op2_ff[2] <= beta_in;
         end
      end
      for (int k = 3; k <= 7; k++) begin
         if (adv[k]) begin
            op1_ff[k] <= op1_ff[k-1];
            op2_ff[k] <= op2_ff[k-1];
         end
      end
      if (adv[8]) begin
         m1_ff <= op1_ff[7] * cos_val;
         m2_ff <= op2_ff[7] * sin_val;
         m3_ff <= op1_ff[7] * sin_val;
         m4_ff <= op2_ff[7] * cos_val;
      end
      if (adv[9]) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      if (adv[10]) begin
         r0_ff[10] <= r0_in;
         r1_ff[10] <= sat_val(s2_r18);
         al2_ff    <= al2_in;
         be2_ff    <= be2_in;
      end
      if (adv[11]) begin
         r0_ff[11] <= r0_ff[10];
         r1_ff[11] <= r1_ff[10];
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
      end
      if (adv[12]) begin
         if (cmd_ff[11] == CMD_FORWARD) begin
            res_d_ff <= r0_ff[11];
            res_q_ff <= r1_ff[11];
            res_a_ff <= '0;
            res_b_ff <= '0;
            res_c_ff <= '0;
         end else begin
            res_d_ff <= '0;
            res_q_ff <= '0;
            res_a_ff <= r0_ff[11];
            res_b_ff <= res_b_in;
            res_c_ff <= res_c_in;
         end
      end
   end

   assign rsp_res_d = res_d_ff;
   assign rsp_res_q = res_q_ff;
   assign rsp_res_a = res_a_ff;
   assign rsp_res_b = res_b_ff;
   assign rsp_res_c = res_c_ff;

endmodule

/* sv/pct_checker.sv */
// Port-level checks for the transform unit, bound to the top level.
`timescale 1ns / 1ps

module pct_checker #(
   parameter int VALUE_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_WIDTH-1:0] rsp_res_d,
   input logic signed [VALUE_WIDTH-1:0] rsp_res_q,
   input logic signed [VALUE_WIDTH-1:0] rsp_res_a,
   input logic signed [VALUE_WIDTH-1:0] rsp_res_b,
   input logic signed [VALUE_WIDTH-1:0] rsp_res_c
);

   // A stalled response transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A stalled response transaction keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_res_d) && $stable(rsp_res_q)
         && $stable(rsp_res_a) && $stable(rsp_res_b) && $stable(rsp_res_c))
      else $error("response payload changed while stalled");

   // With the output register empty every stage can move, so requests are taken.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the output register is empty");

   // Only one direction's results are populated in any response.
   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_res_d == '0 && rsp_res_q == '0)
         || (rsp_res_a == '0 && rsp_res_b == '0 && rsp_res_c == '0))
      else $error("forward and inverse results both populated");

endmodule

bind park_clarke_transform_unit_core pct_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_pct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_res_d (rsp_res_d),
   .rsp_res_q (rsp_res_q),
   .rsp_res_a (rsp_res_a),
   .rsp_res_b (rsp_res_b),
   .rsp_res_c (rsp_res_c)
);
